/* design/tiar_pkg.sv */
package tiar_pkg;

  // item kinds carried on the input tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // field widths
  localparam int ID_W    = 29;
  localparam int COL_W   = 16;
  localparam int CELL_W  = 12;
  localparam int SLOT_W  = 3;
  localparam int TID_W   = 32;
  localparam int RX_W    = 28;
  localparam int RY_W    = 41;
  localparam int IN_W    = 104;
  localparam int OUT_W   = 104;

  // one tileset descriptor
  typedef struct packed {
    logic [ID_W-1:0]   base_id;
    logic [COL_W-1:0]  columns;
    logic [CELL_W-1:0] cell_width;
    logic [CELL_W-1:0] cell_height;
  } tiar_entry_t;

  // read side of the descriptor table
  typedef struct packed {
    logic        valid;
    tiar_entry_t entry;
  } tiar_rd_t;

endpackage

/* design/tiar_table.sv */
module tiar_table #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  tiar_pkg::tiar_entry_t wr_entry,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output tiar_pkg::tiar_rd_t  rd
);
  import tiar_pkg::*;

  tiar_entry_t      mem [DEPTH];
  logic [DEPTH-1:0] valid;
  tiar_entry_t      rd_entry;
  logic             rd_valid;

  assign rd = {rd_valid, rd_entry};

  // descriptor store, no reset; registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

  // valid marks, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

endmodule

/* design/tiar_div.sv */
module tiar_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tiar_pkg::ID_W-1:0]   dividend,
  input  logic [tiar_pkg::COL_W-1:0]  divisor,
  output logic                        done,
  output logic [tiar_pkg::ID_W-1:0]   quotient,
  output logic [tiar_pkg::COL_W-1:0]  remainder
);
  import tiar_pkg::*;

  localparam int CNT_W = $clog2(ID_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [COL_W-1:0] dsr;
  logic [COL_W:0]   rem_sh;
  logic [COL_W:0]   rem_sub;
  logic             ge;

  // one restoring step: shift in the next dividend bit, try to subtract
  assign rem_sh  = {remainder, quotient[ID_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr};
  assign rem_sub = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[ID_W-2:0], ge};
      remainder <= ge ? rem_sub[COL_W-1:0] : rem_sh[COL_W-1:0];
    end
  end

  // step counter, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(ID_W - 1);
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

endmodule

/* design/tile_id_to_atlas_rect_core.sv */
// A query scans the table and, when a rectangle is produced, runs a 29-step divide and
// two multiplies before the result is registered. A load gives no beat.
// Throughput: one item at a time; after a query the next beat is taken only once its
// result is registered and the sequencer is back in idle.
// Reset (rst, synchronous) clears every valid mark and the control.
module tile_id_to_atlas_rect_core #(
  parameter int MAX_TILESETS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // slot[2:0], base_id[31:3], atlas_columns[47:32], cell_width[59:48],
  // cell_height[71:60], tile_id[103:72]
  input  logic [tiar_pkg::IN_W-1:0]   s_axis_tdata,
  // op[0]
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // matched[0], matched_slot[3:1], rect_valid[4], rect_x[32:5], rect_y[73:33],
  // rect_w[85:74], rect_h[97:86], zero[103:98]
  output logic [tiar_pkg::OUT_W-1:0]  m_axis_tdata
);
  import tiar_pkg::*;

  localparam int IDX_W = (MAX_TILESETS > 1) ? $clog2(MAX_TILESETS) : 1;
  localparam int CNT_W = $clog2(MAX_TILESETS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MULX  = 3'd4;
  localparam logic [2:0] S_MULY  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]        state;
  logic [CNT_W-1:0]  scan_idx;
  logic              pend;
  logic [ID_W-1:0]   clean;
  logic              found;
  logic [IDX_W-1:0]  best_idx;
  tiar_entry_t       best;
  logic              rect_ok;
  logic [RX_W-1:0]   rx;
  logic [RY_W-1:0]   ry;

  // input beat fields
  logic [SLOT_W-1:0] in_slot;
  tiar_entry_t       in_entry;
  logic [TID_W-1:0]  in_tile_id;
  logic              accept;
  logic              load_ok;

  assign in_slot              = s_axis_tdata[2:0];
  assign in_entry.base_id     = s_axis_tdata[31:3];
  assign in_entry.columns     = s_axis_tdata[47:32];
  assign in_entry.cell_width  = s_axis_tdata[59:48];
  assign in_entry.cell_height = s_axis_tdata[71:60];
  assign in_tile_id           = s_axis_tdata[103:72];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_ok       = accept && (s_axis_tuser == OP_LOAD) &&
                         (32'(in_slot) < MAX_TILESETS);

  // descriptor table
  logic      rd_en;
  tiar_rd_t  rd;
  assign rd_en = (state == S_SCAN) && (scan_idx < CNT_W'(MAX_TILESETS));

  tiar_table #(
    .DEPTH (MAX_TILESETS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (load_ok),
    .wr_addr  (IDX_W'(in_slot)),
    .wr_entry (in_entry),
    .rd_en    (rd_en),
    .rd_addr  (scan_idx[IDX_W-1:0]),
    .rd
  );

  // divider for local id / columns
  logic             div_start;
  logic             div_done;
  logic [ID_W-1:0]  div_quo;
  logic [COL_W-1:0] div_rem;
  logic             ok_now;

  assign ok_now    = found && (clean != '0) && (best.columns != '0);
  assign div_start = (state == S_START) && ok_now;

  tiar_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (clean - best.base_id),
    .divisor   (best.columns),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // one multiplier, shared by x and y
  logic [ID_W-1:0]   mul_a;
  logic [CELL_W-1:0] mul_b;
  logic [RY_W-1:0]   mul_p;
  assign mul_a = (state == S_MULX) ? ID_W'(div_rem) : div_quo;
  assign mul_b = (state == S_MULX) ? best.cell_width : best.cell_height;
  assign mul_p = RY_W'(mul_a) * RY_W'(mul_b);

  // best-match test on the entry just read
  logic hit;
  assign hit = pend && rd.valid && (rd.entry.base_id <= clean) &&
               (!found || (rd.entry.base_id > best.base_id));

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_idx <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
      best_idx <= '0;
      rect_ok  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (s_axis_tuser == OP_QUERY)) begin
            state    <= S_SCAN;
            scan_idx <= '0;
            pend     <= 1'b0;
            found    <= 1'b0;
            best_idx <= '0;
          end
        end
        S_SCAN: begin
          pend <= rd_en;
          if (rd_en) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (hit) begin
            found    <= 1'b1;
            best_idx <= IDX_W'(scan_idx - 1'b1);
          end
          if (!rd_en && !pend) begin
            state <= S_START;
          end
        end
        S_START: begin
          rect_ok <= ok_now;
          state   <= ok_now ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MULX;
          end
        end
        S_MULX: state <= S_MULY;
        S_MULY: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      clean <= in_tile_id[ID_W-1:0];
    end
    if (hit) begin
      best <= rd.entry;
    end
    if (state == S_START) begin
      rx <= '0;
      ry <= '0;
    end
    if (state == S_MULX) begin
      rx <= mul_p[RX_W-1:0];
    end
    if (state == S_MULY) begin
      ry <= mul_p;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      m_axis_tdata <= {6'b0,
                       rect_ok ? best.cell_height : {CELL_W{1'b0}},
                       rect_ok ? best.cell_width  : {CELL_W{1'b0}},
                       ry,
                       rx,
                       rect_ok,
                       found ? SLOT_W'(best_idx) : {SLOT_W{1'b0}},
                       found};
    end
  end

  // checks
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (best.columns != '0))
    else $error("divider started with zero columns");

  a_rect_needs_match: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[4]) |-> m_axis_tdata[0])
    else $error("rectangle reported without a match");

  a_nomatch_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[3:1] == '0))
    else $error("slot nonzero without a match");

  a_load_no_beat: assert property (@(posedge clk) disable iff (rst)
    (accept && (s_axis_tuser == OP_LOAD) && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("load produced a result beat");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

import tiar_pkg::*;

localparam int SLOT_COUNT = 8;

// one expected or observed result beat, split into its fields
typedef struct packed {
  logic              matched;
  logic [SLOT_W-1:0] slot;
  logic              rect_valid;
  logic [RX_W-1:0]   x;
  logic [RY_W-1:0]   y;
  logic [CELL_W-1:0] w;
  logic [CELL_W-1:0] h;
} atlas_rect_t;

// Tileset table mirror plus the queue of rectangles still owed by the block
class atlas_rect_scoreboard;
  bit                tbl_valid [SLOT_COUNT];
  bit [ID_W-1:0]     tbl_base  [SLOT_COUNT];
  bit [COL_W-1:0]    tbl_cols  [SLOT_COUNT];
  bit [CELL_W-1:0]   tbl_cw    [SLOT_COUNT];
  bit [CELL_W-1:0]   tbl_ch    [SLOT_COUNT];
  atlas_rect_t       due_rects[$];
  int                mismatches;

  function new();
    mismatches = 0;
    foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;
  endfunction

  // lookup of one cleaned id against the table
  function atlas_rect_t predict_rect(logic [TID_W-1:0] tile_id);
    atlas_rect_t         r;
    bit [ID_W-1:0]       clean;
    bit                  found;
    int                  best;
    longint unsigned     lid;
    longint unsigned     cols;
    r = '0;
    clean = tile_id[ID_W-1:0];
    found = 1'b0;
    best = 0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (tbl_valid[k] && tbl_base[k] <= clean &&
          (!found || tbl_base[k] > tbl_base[best])) begin
        best = k;
        found = 1'b1;
      end
    end
    r.matched = found;
    r.slot = found ? SLOT_W'(best) : '0;
    if (found && clean != 0 && tbl_cols[best] != 0) begin
      lid = longint'(clean - tbl_base[best]);
      cols = longint'(tbl_cols[best]);
      r.rect_valid = 1'b1;
      r.w = tbl_cw[best];
      r.h = tbl_ch[best];
      r.x = RX_W'((lid % cols) * longint'(tbl_cw[best]));
      r.y = RY_W'((lid / cols) * longint'(tbl_ch[best]));
    end
    return r;
  endfunction

  // accepted input beat: loads update the table, queries owe one result
  function void note_beat(logic op, logic [IN_W-1:0] data);
    int s;
    if (op == OP_LOAD) begin
      s = int'(data[2:0]);
      if (s < SLOT_COUNT) begin
        tbl_base[s]  = data[31:3];
        tbl_cols[s]  = data[47:32];
        tbl_cw[s]    = data[59:48];
        tbl_ch[s]    = data[71:60];
        tbl_valid[s] = 1'b1;
      end
    end else begin
      due_rects.insert(due_rects.size(), predict_rect(data[103:72]));
    end
  endfunction

  // accepted output beat against the oldest expectation
  function void check_rect(logic [OUT_W-1:0] data);
    atlas_rect_t exp_r;
    atlas_rect_t got;
    bit          bad;
    got.matched    = data[0];
    got.slot       = data[3:1];
    got.rect_valid = data[4];
    got.x          = data[32:5];
    got.y          = data[73:33];
    got.w          = data[85:74];
    got.h          = data[97:86];
    if (due_rects.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat, nothing pending: %h", data);
      return;
    end
    exp_r = due_rects.pop_front();
    bad = (got.matched != exp_r.matched) || (got.slot != exp_r.slot) ||
          (got.rect_valid != exp_r.rect_valid) || (got.x != exp_r.x) ||
          (got.y != exp_r.y) || (got.w != exp_r.w) || (got.h != exp_r.h) ||
          (data[103:98] != '0);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch exp: m=%0d slot=%0d rv=%0d x=%0d y=%0d w=%0d h=%0d",
                 exp_r.matched, exp_r.slot, exp_r.rect_valid, exp_r.x, exp_r.y,
                 exp_r.w, exp_r.h);
        $display("         got: m=%0d slot=%0d rv=%0d x=%0d y=%0d w=%0d h=%0d pad=%0h",
                 got.matched, got.slot, got.rect_valid, got.x, got.y, got.w, got.h,
                 data[103:98]);
      end
    end
  endfunction

  function int pending();
    return due_rects.size();
  endfunction
endclass

module tb_top;

  localparam int RANDOM_ITEMS = 750;
  localparam int DRAIN_CYCLES = 100;
  localparam int IDLE_LIMIT   = 5000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              s_axis_tuser = OP_LOAD;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  atlas_rect_scoreboard sb = new();
  bit                calm = 1'b0;
  int                stall_left = 0;
  int                idle_cycles = 0;

  tile_id_to_atlas_rect_core #(.MAX_TILESETS(SLOT_COUNT)) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  // gap length: mostly none or short, now and then long; none in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 80);
  endfunction

  // drive one beat after a random gap and hold it until taken
  task automatic send_item(logic op, logic [IN_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_beat(op, data);
  endtask

  // load beat; the unused tile id carries noise
  task automatic send_load(int slot, logic [ID_W-1:0] base, logic [COL_W-1:0] cols,
                           logic [CELL_W-1:0] cw, logic [CELL_W-1:0] ch);
    logic [TID_W-1:0] junk;
    junk = $urandom;
    send_item(OP_LOAD, {junk, ch, cw, cols, base, SLOT_W'(slot)});
  endtask

  // query beat; the unused load fields carry noise
  task automatic send_query(logic [TID_W-1:0] tile_id);
    logic [71:0] junk;
    junk = {$urandom, $urandom, 8'($urandom)};
    send_item(OP_QUERY, {tile_id, junk});
  endtask

  // random descriptor, biased towards small column counts and shared base ids
  task automatic random_load();
    int               r;
    int               s;
    logic [ID_W-1:0]  base;
    logic [COL_W-1:0] cols;
    logic [CELL_W-1:0] cw;
    logic [CELL_W-1:0] ch;
    s = $urandom_range(0, SLOT_COUNT - 1);
    r = $urandom_range(0, 99);
    if (r < 35)      base = ID_W'($urandom_range(0, 3000));
    else if (r < 65) base = ID_W'($urandom);
    else if (r < 75) base = '0;
    else if (r < 85) base = sb.tbl_base[$urandom_range(0, SLOT_COUNT - 1)];
    else             base = {ID_W{1'b1}} - ID_W'($urandom_range(0, 50));
    r = $urandom_range(0, 99);
    if (r < 50)      cols = COL_W'($urandom_range(1, 32));
    else if (r < 60) cols = '0;
    else if (r < 70) cols = COL_W'(1);
    else             cols = COL_W'($urandom);
    r = $urandom_range(0, 9);
    cw = (r == 0) ? '0 : (r == 1) ? '1 : CELL_W'($urandom);
    r = $urandom_range(0, 9);
    ch = (r == 0) ? '0 : (r == 1) ? '1 : CELL_W'($urandom);
    send_load(s, base, cols, cw, ch);
  endtask

  // random query, mostly near the base of a loaded tileset
  task automatic random_query();
    int               r;
    int               k;
    logic [ID_W-1:0]  clean;
    logic [2:0]       flips;
    flips = ($urandom_range(0, 1) == 0) ? 3'b000 : 3'($urandom);
    k = $urandom_range(0, SLOT_COUNT - 1);
    r = $urandom_range(0, 99);
    if (r < 65 && sb.tbl_valid[k]) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        clean = sb.tbl_base[k] + ID_W'($urandom_range(0, int'(sb.tbl_cols[k]) * 3 + 4));
      else if (r < 85)
        clean = sb.tbl_base[k] + ID_W'($urandom_range(0, 4095));
      else
        clean = sb.tbl_base[k] + ID_W'($urandom);
    end else if (r < 75 && sb.tbl_valid[k]) begin
      clean = sb.tbl_base[k] - ID_W'($urandom_range(0, 1));
    end else begin
      clean = ID_W'($urandom);
    end
    send_query({flips, clean});
  endtask

  // result side: check taken beats, then choose the next ready level
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_rect(m_axis_tdata);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, flip bits, ties, zero columns, field extremes
    send_query(32'h0000_0000);
    send_query(32'hFFFF_FFFF);
    send_load(0, 29'd1, 16'd4, 12'd16, 12'd16);
    send_query(32'h0000_0000);
    send_query(32'hE000_0001);
    send_query(32'h0000_000A);
    send_load(7, 29'h1FFF_FFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
    send_query(32'hFFFF_FFFF);
    send_query(32'h1FFF_FFFE);
    send_load(3, 29'd100, 16'd0, 12'd5, 12'd5);
    send_query(32'h0000_0096);
    send_load(5, 29'd100, 16'd3, 12'd7, 12'd9);
    send_query(32'h4000_0064);
    send_load(1, 29'd0, 16'd1, 12'hFFF, 12'hFFF);
    send_query(32'h0000_0000);
    send_query(32'h0000_0032);
    send_load(2, 29'd0, 16'hFFFF, 12'hFFF, 12'd0);
    send_load(4, 29'd200, 16'hFFFF, 12'hFFF, 12'hFFF);
    send_load(6, 29'd200, 16'd1, 12'd0, 12'hFFF);
    send_query(32'h0001_00C7);
    send_load(3, 29'd150, 16'd1, 12'hFFF, 12'hFFF);
    send_load(5, 29'd150, 16'd2, 12'd1, 12'd1);
    send_load(4, 29'd150, 16'd1, 12'hFFF, 12'hFFF);
    send_load(6, 29'd150, 16'd1, 12'hFFF, 12'hFFF);
    send_load(7, 29'd151, 16'd1, 12'hFFF, 12'hFFF);
    send_query(32'h1FFF_FFFF);

    // random mix, with calm stretches where neither side idles
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 300 && i < 400) || (i >= 650);
      if ($urandom_range(0, 99) < 25) random_load();
      else random_query();
    end
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* tile_id_to_atlas_rect_core.f */
design/tiar_pkg.sv
design/tiar_table.sv
design/tiar_div.sv
design/tile_id_to_atlas_rect_core.sv
sim/tb_top.sv
